>>> rtl/core/assert_macros.svh
// assertion macros shared by the well disc pixel sum rtl
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock edge outside reset
`define WDPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition that must be followed by another in the next cycle
`define WDPS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> rtl/core/wdps_pkg.sv
// package for the well disc pixel sum block
// field widths, codes, controller states and the cell control struct; no dependencies
package wdps_pkg;

	localparam int FUNC_W     = 2;
	localparam int WELL_W     = 6;
	localparam int COORD_W    = 12;
	localparam int PIX_W      = 16;
	localparam int SUM_W      = 40;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam int NWELL_W    = 7;
	localparam int R2_W       = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WELLS  = 1'b1;

	localparam logic [R2_W-1:0]    R2_RESET    = 16'd256;
	localparam logic [NWELL_W-1:0] NWELL_RESET = 7'd64;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_PIXEL = 2'd1,
		FUNC_EOF   = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_UNLOAD
	} ctl_state_t;

	typedef struct packed {
		logic acc;
		logic shift;
	} cell_ctl_t;

endpackage

>>> rtl/core/wdps_in_if.sv
// input channel of the well disc pixel sum block: valid, ready and one item
// depends on wdps_pkg
interface wdps_in_if;
	import wdps_pkg::*;

	logic               valid;
	logic               ready;
	logic [FUNC_W-1:0]  func;
	logic [WELL_W-1:0]  well_index;
	logic [COORD_W-1:0] center_x;
	logic [COORD_W-1:0] center_y;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	logic [PIX_W-1:0]   pixel_value;

	modport source (
		output valid, func, well_index, center_x, center_y, pixel_x, pixel_y, pixel_value,
		input  ready
	);

	modport sink (
		input  valid, func, well_index, center_x, center_y, pixel_x, pixel_y, pixel_value,
		output ready
	);

endinterface

>>> rtl/core/wdps_out_if.sv
// result channel of the well disc pixel sum block: valid, ready and one well sum
// depends on wdps_pkg
interface wdps_out_if;
	import wdps_pkg::*;

	logic              valid;
	logic              ready;
	logic [WELL_W-1:0] result_well;
	logic [SUM_W-1:0]  well_sum;
	logic              last;

	modport source (
		output valid, result_well, well_sum, last,
		input  ready
	);

	modport sink (
		input  valid, result_well, well_sum, last,
		output ready
	);

endinterface

>>> rtl/core/wdps_cell.sv
// one well cell: center registers, distance pipeline and saturating accumulator
// accumulators form a shift chain toward cell 0 for readout; depends on wdps_pkg
module wdps_cell #(
	parameter int COORD_BITS = 12,
	parameter int PIXEL_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  wdps_pkg::cell_ctl_t       ctl,
	input  logic                      load,
	input  logic                      active,
	input  logic [COORD_BITS-1:0]     ctr_x,
	input  logic [COORD_BITS-1:0]     ctr_y,
	input  logic [COORD_BITS-1:0]     pix_x,
	input  logic [COORD_BITS-1:0]     pix_y,
	input  logic [PIXEL_BITS-1:0]     val_s3,
	input  logic [2*COORD_BITS:0]     r2,
	input  logic [wdps_pkg::SUM_W-1:0] shift_in,
	output logic [wdps_pkg::SUM_W-1:0] shift_out
);
	import wdps_pkg::*;

	localparam int SQ_W = 2 * COORD_BITS;
	localparam int DW   = SQ_W + 1;

	logic [COORD_BITS-1:0] ctr_x_q;
	logic [COORD_BITS-1:0] ctr_y_q;
	logic [COORD_BITS-1:0] dx_s1;
	logic [COORD_BITS-1:0] dy_s1;
	logic [SQ_W-1:0]       sqx_s2;
	logic [SQ_W-1:0]       sqy_s2;
	logic                  hit_s3;
	logic [SUM_W-1:0]      acc_q;
	logic [SUM_W:0]        sum_w;
	logic [DW-1:0]         dist_w;

	always_ff @(posedge clk) begin
		if (load) begin
			ctr_x_q <= ctr_x;
			ctr_y_q <= ctr_y;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1  <= (pix_x >= ctr_x_q) ? pix_x - ctr_x_q : ctr_x_q - pix_x;
		dy_s1  <= (pix_y >= ctr_y_q) ? pix_y - ctr_y_q : ctr_y_q - pix_y;
		sqx_s2 <= SQ_W'(dx_s1) * SQ_W'(dx_s1);
		sqy_s2 <= SQ_W'(dy_s1) * SQ_W'(dy_s1);
		hit_s3 <= dist_w < r2;
	end

	assign dist_w = DW'(sqx_s2) + DW'(sqy_s2);
	assign sum_w  = (SUM_W+1)'(acc_q) + (SUM_W+1)'(val_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.shift) begin
			acc_q <= shift_in;
		end else if (ctl.acc && hit_s3 && active) begin
			acc_q <= sum_w[SUM_W] ? '1 : sum_w[SUM_W-1:0];
		end
	end

	// inactive wells hand zero down the chain so readout also clears them
	assign shift_out = active ? acc_q : '0;

endmodule

>>> rtl/core/well_disc_pixel_sum_top.sv
// Well disc pixel sum: table of well centers held in a row of cells,
// each cell testing every streamed pixel against its own disc.
// Usage:
//   Channels: item (in) carries func, well_index, center_x/y, pixel_x/y and
//   pixel_value; result (out) carries result_well, well_sum and last.
//   A transfer happens when valid and ready are both high at a clock edge.
//   Configuration: cfg_we with cfg_idx 0 sets the disc radius, cfg_idx 1 the
//   number of wells in use; write only while the block is idle.
//   Load and pixel items may follow back to back while the block is idle;
//   a pixel passes stages s1, s2 and s3 on its way to the accumulators.
//   An end-of-frame item waits for pixels in flight to drain, then
//   the accumulator chain shifts toward cell 0, giving one well sum per cycle
//   while results are taken, in index order; from the end-of-frame transfer
//   until the last well sum has shifted out, through the drain and unload
//   states, no item is taken. A stalled result holds the chain.
//   Reset clears all sums, sets radius 16 and 64 wells in use; well centers
//   must be loaded before pixels are sent.
`include "assert_macros.svh"

module well_disc_pixel_sum_top #(
	parameter int MAX_WELLS  = 64,
	parameter int PIXEL_BITS = 16,
	parameter int COORD_BITS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [wdps_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [wdps_pkg::CFG_DATA_W-1:0] cfg_data,
	wdps_in_if.sink                         item,
	wdps_out_if.source                      result
);
	import wdps_pkg::*;

	localparam int DW = 2 * COORD_BITS + 1;

	logic [R2_W-1:0]       r2_q;
	logic [NWELL_W-1:0]    n_q;
	logic [NWELL_W-1:0]    n_eff;
	logic [NWELL_W-1:0]    n_last;
	ctl_state_t            state_q;
	ctl_state_t            state_d;
	logic                  vld_s1_q;
	logic                  vld_s2_q;
	logic                  vld_s3_q;
	logic [PIXEL_BITS-1:0] val_s1;
	logic [PIXEL_BITS-1:0] val_s2;
	logic [PIXEL_BITS-1:0] val_s3;
	logic                  in_fire;
	logic                  pix_fire;
	logic                  ld_fire;
	logic                  eof_fire;
	logic                  out_take;
	logic                  shift;
	logic                  last_w;
	logic [WELL_W-1:0]     out_idx_q;
	logic                  out_vld_q;
	logic [WELL_W-1:0]     result_well_q;
	logic [SUM_W-1:0]      well_sum_q;
	logic                  last_q;
	cell_ctl_t             cell_ctl;
	logic [MAX_WELLS-1:0]  active;
	logic [SUM_W-1:0]      chain [MAX_WELLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r2_q <= R2_RESET;
			n_q  <= NWELL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_RADIUS: r2_q <= R2_W'(cfg_data) * R2_W'(cfg_data);
				CFG_WELLS:  n_q  <= cfg_data[NWELL_W-1:0];
				default:    r2_q <= r2_q;
			endcase
		end
	end

	always_comb begin
		if (n_q == '0) begin
			n_eff = NWELL_W'(1);
		end else if (n_q > NWELL_W'(MAX_WELLS)) begin
			n_eff = NWELL_W'(MAX_WELLS);
		end else begin
			n_eff = n_q;
		end
	end

	assign n_last   = n_eff - NWELL_W'(1);
	assign last_w   = {1'b0, out_idx_q} == n_last;
	assign in_fire  = item.valid && item.ready;
	assign pix_fire = in_fire && (item.func == FUNC_PIXEL);
	assign ld_fire  = in_fire && (item.func == FUNC_LOAD);
	assign eof_fire = in_fire && (item.func == FUNC_EOF);
	assign out_take = !out_vld_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		shift      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item.ready = 1'b1;
				if (eof_fire) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!(vld_s1_q || vld_s2_q || vld_s3_q)) begin
					state_d = ST_UNLOAD;
				end
			end
			ST_UNLOAD: begin
				shift = out_take;
				if (out_take && last_w) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// pixel pipeline, shared by all cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1_q <= 1'b0;
			vld_s2_q <= 1'b0;
			vld_s3_q <= 1'b0;
		end else begin
			vld_s1_q <= pix_fire;
			vld_s2_q <= vld_s1_q;
			vld_s3_q <= vld_s2_q;
		end
	end

	always_ff @(posedge clk) begin
		val_s1 <= item.pixel_value[PIXEL_BITS-1:0];
		val_s2 <= val_s1;
		val_s3 <= val_s2;
	end

	assign cell_ctl.acc   = vld_s3_q;
	assign cell_ctl.shift = shift;

	for (genvar i = 0; i < MAX_WELLS; i++) begin : g_cell
		logic [SUM_W-1:0] shift_in;

		if (i == MAX_WELLS - 1) begin : g_end
			assign shift_in = '0;
		end else begin : g_mid
			assign shift_in = chain[i+1];
		end

		assign active[i] = NWELL_W'(i) < n_eff;

		wdps_cell #(
			.COORD_BITS (COORD_BITS),
			.PIXEL_BITS (PIXEL_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (cell_ctl),
			.load      (ld_fire && (item.well_index == WELL_W'(i))),
			.active    (active[i]),
			.ctr_x     (item.center_x[COORD_BITS-1:0]),
			.ctr_y     (item.center_y[COORD_BITS-1:0]),
			.pix_x     (item.pixel_x[COORD_BITS-1:0]),
			.pix_y     (item.pixel_y[COORD_BITS-1:0]),
			.val_s3    (val_s3),
			.r2        (DW'(r2_q)),
			.shift_in  (shift_in),
			.shift_out (chain[i])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			out_idx_q <= '0;
		end else if (shift) begin
			out_vld_q <= 1'b1;
			out_idx_q <= last_w ? '0 : out_idx_q + WELL_W'(1);
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			result_well_q <= out_idx_q;
			well_sum_q    <= chain[0];
			last_q        <= last_w;
		end
	end

	assign result.valid       = out_vld_q;
	assign result.result_well = result_well_q;
	assign result.well_sum    = well_sum_q;
	assign result.last        = last_q;

	`WDPS_ASSERT(a_shift_drained, shift |-> !(vld_s1_q || vld_s2_q || vld_s3_q), "readout with pixel in flight")
	`WDPS_ASSERT(a_idx_in_range, (state_q == ST_UNLOAD) |-> ({1'b0, out_idx_q} < n_eff), "result index past wells in use")
	`WDPS_ASSERT_NEXT(a_last_ends, shift && last_w, (state_q == ST_IDLE) && (out_idx_q == '0), "readout did not end")
	`WDPS_ASSERT(a_out_from_unload, $rose(out_vld_q) |-> $past(state_q == ST_UNLOAD), "result outside readout")

endmodule
